// ===== sv/qcc_pkg.sv =====
// Shared types, constants and arithmetic helpers for the QAM compensation and LLR block.
package qcc_pkg;

    // Sample precision taken from the low bits of each input part
    localparam int SAMPLE_WIDTH = 16;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    // Number of soft bits per modulation
    localparam logic [2:0] LLR_CNT_QPSK  = 3'd2;
    localparam logic [2:0] LLR_CNT_16QAM = 3'd4;
    localparam logic [2:0] LLR_CNT_64QAM = 3'd6;

    typedef enum logic [1:0] {
        MOD_QPSK  = 2'd0,
        MOD_16QAM = 2'd1,
        MOD_64QAM = 2'd2
    } t_mod;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODULATION = 2'd0,
        CFG_SHIFT      = 2'd1,
        CFG_AMP_A      = 2'd2,
        CFG_AMP_B      = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        t_mod               modulation;
        logic [4:0]         prod_shift;
        logic signed [15:0] amp_a;
        logic signed [15:0] amp_b;
    } t_cfg;

    typedef struct packed {
        logic signed [15:0] rx_re;
        logic signed [15:0] rx_im;
        logic signed [15:0] ch_re;
        logic signed [15:0] ch_im;
        logic               last_element;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] comp_re;
        logic signed [15:0] comp_im;
        logic signed [15:0] thr_a;
        logic signed [15:0] thr_b;
        logic signed [15:0] llr_0;
        logic signed [15:0] llr_1;
        logic signed [15:0] llr_2;
        logic signed [15:0] llr_3;
        logic signed [15:0] llr_4;
        logic signed [15:0] llr_5;
        logic [2:0]         llr_count;
        logic               last;
    } t_out_item;

    // Stage 1: raw products
    typedef struct packed {
        logic signed [31:0] p_cr_rr;
        logic signed [31:0] p_ci_ri;
        logic signed [31:0] p_nci_rr;
        logic signed [31:0] p_cr_ri;
        logic signed [31:0] p_cr_cr;
        logic signed [31:0] p_ci_ci;
        logic               last;
    } t_s1;

    // Stage 2: compensated sample and channel energy, shifted and saturated
    typedef struct packed {
        logic signed [15:0] comp_re;
        logic signed [15:0] comp_im;
        logic signed [15:0] energy;
        logic               last;
    } t_s2;

    // Stage 3: energy scaled by both amplitude constants
    typedef struct packed {
        logic signed [15:0] comp_re;
        logic signed [15:0] comp_im;
        logic signed [31:0] prod_a;
        logic signed [31:0] prod_b;
        logic               last;
    } t_s3;

    // Stage 4: thresholds and first-level soft bits
    typedef struct packed {
        logic signed [15:0] comp_re;
        logic signed [15:0] comp_im;
        logic signed [15:0] thr_a;
        logic signed [15:0] thr_b;
        logic signed [15:0] a_re;
        logic signed [15:0] a_im;
        logic               last;
    } t_s4;

    // Sign-extend the low SAMPLE_WIDTH bits of an input part
    function automatic logic signed [15:0] sext_in(input logic [15:0] v);
        logic signed [SAMPLE_WIDTH-1:0] t;
        t = v[SAMPLE_WIDTH-1:0];
        return 16'(t);
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
        if (v > 32'sd32767) begin
            return 16'sh7fff;
        end else if (v < -32'sd32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    // Absolute value; the most negative code maps to itself
    function automatic logic signed [15:0] abs16(input logic signed [15:0] v);
        logic signed [15:0] n;
        n = -v;
        return v[15] ? n : v;
    endfunction

    // Saturating 16-bit subtract
    function automatic logic signed [15:0] subs16(input logic signed [15:0] a,
                                                  input logic signed [15:0] b);
        logic signed [16:0] d;
        d = {a[15], a} - {b[15], b};
        if (d[16] != d[15]) begin
            return d[16] ? 16'sh8000 : 16'sh7fff;
        end
        return d[15:0];
    endfunction

endpackage

// ===== sv/qcc_cmul.sv =====
// Conjugate multiply and channel energy: product stage then shift/saturate stage.
module qcc_cmul (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  qcc_pkg::t_cfg    i_cfg,
    input  logic             i_valid,
    input  qcc_pkg::t_in_item i_item,
    output logic             o_ready,
    output logic             o_valid,
    output qcc_pkg::t_s2     o_data,
    input  logic             i_ready
);
    import qcc_pkg::*;

    logic r_v1;
    logic r_v2;
    t_s1  r_s1;
    t_s1  n_s1;
    t_s2  r_s2;
    t_s2  n_s2;
    logic ready1;
    logic ready2;

    logic signed [15:0] rr;
    logic signed [15:0] ri;
    logic signed [15:0] cr;
    logic signed [15:0] ci;
    logic signed [15:0] nci;
    logic signed [31:0] sum_re;
    logic signed [31:0] sum_im;
    logic signed [31:0] sum_e;

    // Stage handshake: a stage loads when empty or when its content moves on
    assign ready2  = !r_v2 || i_ready;
    assign ready1  = !r_v1 || ready2;
    assign o_ready = ready1;
    assign o_valid = r_v2;
    assign o_data  = r_s2;

    // Stage 1: the six products
    always_comb begin
        rr  = sext_in(i_item.rx_re);
        ri  = sext_in(i_item.rx_im);
        cr  = sext_in(i_item.ch_re);
        ci  = sext_in(i_item.ch_im);
        nci = -ci;
        n_s1.p_cr_rr  = 32'(cr) * 32'(rr);
        n_s1.p_ci_ri  = 32'(ci) * 32'(ri);
        n_s1.p_nci_rr = 32'(nci) * 32'(rr);
        n_s1.p_cr_ri  = 32'(cr) * 32'(ri);
        n_s1.p_cr_cr  = 32'(cr) * 32'(cr);
        n_s1.p_ci_ci  = 32'(ci) * 32'(ci);
        n_s1.last     = i_item.last_element;
    end

    // Stage 2: wrapping sums, arithmetic shift, saturation
    always_comb begin
        sum_re = r_s1.p_cr_rr + r_s1.p_ci_ri;
        sum_im = r_s1.p_nci_rr + r_s1.p_cr_ri;
        sum_e  = r_s1.p_cr_cr + r_s1.p_ci_ci;
        n_s2.comp_re = sat16(sum_re >>> i_cfg.prod_shift);
        n_s2.comp_im = sat16(sum_im >>> i_cfg.prod_shift);
        n_s2.energy  = sat16(sum_e >>> i_cfg.prod_shift);
        n_s2.last    = r_s1.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (ready1) r_v1 <= i_valid;
            if (ready2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready1 && i_valid) r_s1 <= n_s1;
        if (ready2 && r_v1)    r_s2 <= n_s2;
    end

endmodule

// ===== sv/qcc_thr.sv =====
// Threshold scaling stage: channel energy times both amplitude constants.
module qcc_thr (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  qcc_pkg::t_cfg i_cfg,
    input  logic          i_valid,
    input  qcc_pkg::t_s2  i_data,
    output logic          o_ready,
    output logic          o_valid,
    output qcc_pkg::t_s3  o_data,
    input  logic          i_ready
);
    import qcc_pkg::*;

    logic r_v3;
    t_s3  r_s3;
    t_s3  n_s3;
    logic ready3;

    assign ready3  = !r_v3 || i_ready;
    assign o_ready = ready3;
    assign o_valid = r_v3;
    assign o_data  = r_s3;

    // One 16x16 product per threshold
    always_comb begin
        n_s3.comp_re = i_data.comp_re;
        n_s3.comp_im = i_data.comp_im;
        n_s3.prod_a  = 32'(i_data.energy) * 32'(i_cfg.amp_a);
        n_s3.prod_b  = 32'(i_data.energy) * 32'(i_cfg.amp_b);
        n_s3.last    = i_data.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (ready3) begin
            r_v3 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready3 && i_valid) r_s3 <= n_s3;
    end

endmodule

// ===== sv/qcc_llr.sv =====
// Soft demapper: threshold/first-level stage, then second-level and output register.
module qcc_llr (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  qcc_pkg::t_cfg      i_cfg,
    input  logic               i_valid,
    input  qcc_pkg::t_s3       i_data,
    output logic               o_ready,
    output logic               o_valid,
    output qcc_pkg::t_out_item o_item,
    input  logic               i_ready
);
    import qcc_pkg::*;

    logic      r_v4;
    logic      r_v5;
    t_s4       r_s4;
    t_s4       n_s4;
    t_out_item r_out;
    t_out_item n_out;
    logic      ready4;
    logic      ready5;
    logic      use_thr;
    logic signed [15:0] b_re;
    logic signed [15:0] b_im;

    assign ready5  = !r_v5 || i_ready;
    assign ready4  = !r_v4 || ready5;
    assign o_ready = ready4;
    assign o_valid = r_v5;
    assign o_item  = r_out;

    // Stage 4: high half of product doubled, then |x| - thr_a
    always_comb begin
        use_thr = (i_cfg.modulation == MOD_16QAM) || (i_cfg.modulation == MOD_64QAM);
        n_s4.comp_re = i_data.comp_re;
        n_s4.comp_im = i_data.comp_im;
        n_s4.thr_a   = use_thr ? {i_data.prod_a[30:16], 1'b0} : 16'sd0;
        n_s4.thr_b   = use_thr ? {i_data.prod_b[30:16], 1'b0} : 16'sd0;
        n_s4.a_re    = subs16(abs16(i_data.comp_re), n_s4.thr_a);
        n_s4.a_im    = subs16(abs16(i_data.comp_im), n_s4.thr_a);
        n_s4.last    = i_data.last;
    end

    // Stage 5: |a| - thr_b and soft-bit ordering per modulation
    always_comb begin
        b_re = subs16(abs16(r_s4.a_re), r_s4.thr_b);
        b_im = subs16(abs16(r_s4.a_im), r_s4.thr_b);
        n_out.comp_re = r_s4.comp_re;
        n_out.comp_im = r_s4.comp_im;
        n_out.thr_a   = r_s4.thr_a;
        n_out.thr_b   = r_s4.thr_b;
        n_out.llr_0   = r_s4.comp_re;
        n_out.last    = r_s4.last;
        unique case (i_cfg.modulation)
            MOD_16QAM: begin
                n_out.llr_1     = r_s4.a_re;
                n_out.llr_2     = r_s4.comp_im;
                n_out.llr_3     = r_s4.a_im;
                n_out.llr_4     = 16'sd0;
                n_out.llr_5     = 16'sd0;
                n_out.llr_count = LLR_CNT_16QAM;
            end
            MOD_64QAM: begin
                n_out.llr_1     = r_s4.a_re;
                n_out.llr_2     = b_re;
                n_out.llr_3     = r_s4.comp_im;
                n_out.llr_4     = r_s4.a_im;
                n_out.llr_5     = b_im;
                n_out.llr_count = LLR_CNT_64QAM;
            end
            default: begin
                // QPSK and the unused code
                n_out.llr_1     = r_s4.comp_im;
                n_out.llr_2     = 16'sd0;
                n_out.llr_3     = 16'sd0;
                n_out.llr_4     = 16'sd0;
                n_out.llr_5     = 16'sd0;
                n_out.llr_count = LLR_CNT_QPSK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (ready4) r_v4 <= i_valid;
            if (ready5) r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready4 && i_valid) r_s4  <= n_s4;
        if (ready5 && r_v4)    r_out <= n_out;
    end

endmodule

// ===== sv/qam_channel_compensation_llr.sv =====
// Throughput: one resource element per cycle; five register stages (products, shift/saturate,
//   threshold products, first-level LLRs, second-level LLRs/output); a full stage holds.
// An accepted input is loaded into the first of the five stages and moves through them in order.
// Reset (i_rst_n low, synchronous): all stage valid bits clear and the configuration
//   registers return to QPSK, zero shift and zero amplitudes; payload registers are not reset.
module qam_channel_compensation_llr (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [qcc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [qcc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  qcc_pkg::t_in_item                   i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output qcc_pkg::t_out_item                  o_out_item
);
    import qcc_pkg::*;

    t_cfg r_cfg;
    logic cmul_ready;
    logic s2_valid;
    t_s2  s2_data;
    logic thr_ready;
    logic s3_valid;
    t_s3  s3_data;
    logic llr_ready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.modulation <= MOD_QPSK;
            r_cfg.prod_shift <= '0;
            r_cfg.amp_a      <= '0;
            r_cfg.amp_b      <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_MODULATION: r_cfg.modulation <= t_mod'(i_cfg_data[1:0]);
                CFG_SHIFT:      r_cfg.prod_shift <= i_cfg_data[4:0];
                CFG_AMP_A:      r_cfg.amp_a      <= i_cfg_data;
                CFG_AMP_B:      r_cfg.amp_b      <= i_cfg_data;
            endcase
        end
    end

    assign o_in_stall = !cmul_ready;

    qcc_cmul u_cmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_in_valid),
        .i_item  (i_in_item),
        .o_ready (cmul_ready),
        .o_valid (s2_valid),
        .o_data  (s2_data),
        .i_ready (thr_ready)
    );

    qcc_thr u_thr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (s2_valid),
        .i_data  (s2_data),
        .o_ready (thr_ready),
        .o_valid (s3_valid),
        .o_data  (s3_data),
        .i_ready (llr_ready)
    );

    qcc_llr u_llr (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (s3_valid),
        .i_data  (s3_data),
        .o_ready (llr_ready),
        .o_valid (o_out_valid),
        .o_item  (o_out_item),
        .i_ready (!i_out_stall)
    );

    // Input backpressure only when the whole pipe is full behind a stalled output
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled while pipeline has room");

    a_count_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.llr_count == LLR_CNT_QPSK ||
                         o_out_item.llr_count == LLR_CNT_16QAM ||
                         o_out_item.llr_count == LLR_CNT_64QAM))
        else $error("illegal soft-bit count");

    a_qpsk_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_cfg.modulation == MOD_QPSK) |->
            (o_out_item.thr_a == '0 && o_out_item.thr_b == '0 &&
             o_out_item.llr_2 == '0 && o_out_item.llr_count == LLR_CNT_QPSK))
        else $error("QPSK result carries thresholds or extra soft bits");

    a_llr0_re: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.llr_0 == o_out_item.comp_re))
        else $error("first soft bit differs from compensated real part");

endmodule

// ===== dv/qam_channel_compensation_llr_tb.sv =====
// Self-checking testbench for the QAM channel compensation and max-log LLR block.
module qam_channel_compensation_llr_tb;
    import qcc_pkg::*;

    localparam int LATENCY       = 4;
    localparam int IDLE_LIMIT    = 4000;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 107;
    localparam int MAX_REPORTS   = 10;

    // Modulation code with no meaning of its own; the block falls back to QPSK
    localparam logic [1:0] MOD_UNUSED = 2'd3;

    // Local copy of the configuration registers
    typedef struct {
        logic [1:0]         modulation;
        logic [4:0]         shift;
        logic signed [15:0] amp_a;
        logic signed [15:0] amp_b;
    } t_reg_shadow;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in_item   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out_item;

    t_reg_shadow shadow        = '{2'd0, 5'd0, 16'sd0, 16'sd0};
    t_out_item   pending_llrs[$];
    t_out_item   want;
    int          mismatch_count  = 0;
    int          results_checked = 0;
    int          quiet_cycles    = 0;
    bit          sender_steady   = 1'b0;

    qam_channel_compensation_llr u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    // Low SAMPLE_WIDTH bits of an input part, sign-extended
    function automatic logic signed [15:0] narrow_sample(input logic [15:0] v);
        logic signed [15:0] s;
        s = v << (16 - SAMPLE_WIDTH);
        return s >>> (16 - SAMPLE_WIDTH);
    endfunction

    function automatic logic signed [15:0] clip16(input logic signed [31:0] v);
        if (v[31:15] == {17{v[31]}}) begin
            return v[15:0];
        end
        return v[31] ? 16'sh8000 : 16'sh7fff;
    endfunction

    // |v|, most negative code stays put
    function automatic logic signed [15:0] mag16(input logic signed [15:0] v);
        if (v == 16'sh8000) begin
            return v;
        end
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic signed [15:0] sub_clip(input logic signed [15:0] a,
                                                    input logic signed [15:0] b);
        return clip16(32'(a) - 32'(b));
    endfunction

    // High half of energy * amplitude, doubled with 16-bit wrap
    function automatic logic signed [15:0] threshold_of(input logic signed [15:0] e,
                                                        input logic signed [15:0] amp);
        logic signed [31:0] prod;
        logic signed [31:0] hi;
        prod = 32'(e) * 32'(amp);
        hi   = prod >>> 16;
        return {hi[14:0], 1'b0};
    endfunction

    function automatic t_out_item demap_element(input t_in_item it, input t_reg_shadow c);
        logic signed [15:0] rr, ri, cr, ci, nci;
        logic signed [15:0] re, im, en, ta, tb, a_re, a_im;
        logic signed [31:0] re_w, im_w, en_w;
        t_out_item          res;
        rr  = narrow_sample(it.rx_re);
        ri  = narrow_sample(it.rx_im);
        cr  = narrow_sample(it.ch_re);
        ci  = narrow_sample(it.ch_im);
        nci = -ci;

        // sample times conjugate channel, 32-bit wrap, then shift and clip
        re_w = 32'(cr) * 32'(rr) + 32'(ci) * 32'(ri);
        im_w = 32'(nci) * 32'(rr) + 32'(cr) * 32'(ri);
        re   = clip16(re_w >>> c.shift);
        im   = clip16(im_w >>> c.shift);

        ta = '0;
        tb = '0;
        if (c.modulation == MOD_16QAM || c.modulation == MOD_64QAM) begin
            en_w = 32'(cr) * 32'(cr) + 32'(ci) * 32'(ci);
            en   = clip16(en_w >>> c.shift);
            ta   = threshold_of(en, c.amp_a);
            tb   = threshold_of(en, c.amp_b);
        end
        a_re = sub_clip(mag16(re), ta);
        a_im = sub_clip(mag16(im), ta);

        res         = '0;
        res.comp_re = re;
        res.comp_im = im;
        res.thr_a   = ta;
        res.thr_b   = tb;
        res.llr_0   = re;
        res.last    = it.last_element;
        case (c.modulation)
            MOD_16QAM: begin
                res.llr_1     = a_re;
                res.llr_2     = im;
                res.llr_3     = a_im;
                res.llr_count = LLR_CNT_16QAM;
            end
            MOD_64QAM: begin
                res.llr_1     = a_re;
                res.llr_2     = sub_clip(mag16(a_re), tb);
                res.llr_3     = im;
                res.llr_4     = a_im;
                res.llr_5     = sub_clip(mag16(a_im), tb);
                res.llr_count = LLR_CNT_64QAM;
            end
            default: begin
                res.llr_1     = im;
                res.llr_count = LLR_CNT_QPSK;
            end
        endcase
        return res;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Sample value biased toward the corners and small magnitudes
    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 19))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            3:       return 16'hffff;
            4, 5, 6: return 16'($urandom_range(0, 1023) - 512);
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_MODULATION: shadow.modulation = data[1:0];
            CFG_SHIFT:      shadow.shift      = data[4:0];
            CFG_AMP_A:      shadow.amp_a      = data;
            CFG_AMP_B:      shadow.amp_b      = data;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Unused upper data bits are filled with noise; the block keeps only the field
    task automatic configure(input logic [1:0] modulation, input logic [4:0] shift,
                             input logic signed [15:0] amp_a,
                             input logic signed [15:0] amp_b);
        write_reg(CFG_MODULATION, {14'($urandom()), modulation});
        write_reg(CFG_SHIFT, {11'($urandom()), shift});
        write_reg(CFG_AMP_A, amp_a);
        write_reg(CFG_AMP_B, amp_b);
    endtask

    // One input transaction, then an optional idle gap with junk on the payload
    task automatic send_element(input t_in_item item);
        int gap;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_item  <= item;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        pending_llrs.push_back(demap_element(item, shadow));
        gap = sender_steady ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            i_in_item  <= t_in_item'(65'({$urandom(), $urandom(), $urandom()}));
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_fields(input logic signed [15:0] rx_re, input logic signed [15:0] rx_im,
                               input logic signed [15:0] ch_re, input logic signed [15:0] ch_im,
                               input logic last_element);
        t_in_item item;
        item.rx_re        = rx_re;
        item.rx_im        = rx_im;
        item.ch_re        = ch_re;
        item.ch_im        = ch_im;
        item.last_element = last_element;
        send_element(item);
    endtask

    task automatic drop_valid();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    // Hold off the sender until every outstanding result has come back
    task automatic wait_drained();
        drop_valid();
        while (pending_llrs.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 1) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------- tests

    // Registers at their reset values: QPSK, no shift
    task automatic test_reset_state();
        send_fields(16'sd100, -16'sd200, 16'sd3, 16'sd4, 1'b0);
        // every part most negative: the 32-bit sum wraps
        send_fields(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 1'b1);
    endtask

    task automatic test_qpsk_extremes();
        wait_drained();
        configure(MOD_QPSK, 5'd0, 16'sd0, 16'sd0);
        send_fields(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0);
        // conjugate of the most negative channel imaginary part
        send_fields(16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 1'b1);
        send_fields(16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0);
        wait_drained();
        configure(MOD_QPSK, 5'd31, 16'sh7fff, 16'sh8000);
        send_fields(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 1'b0);
        send_fields(16'sd1, -16'sd1, 16'sd1, 16'sd1, 1'b1);
    endtask

    task automatic test_16qam_thresholds();
        wait_drained();
        configure(MOD_16QAM, 5'd15, 16'sd12000, 16'sd5000);
        send_fields(16'sd20000, -16'sd15000, 16'sd9000, -16'sd7000, 1'b0);
        send_fields(-16'sd300, 16'sd400, 16'sh7fff, 16'sd0, 1'b0);
        wait_drained();
        configure(MOD_16QAM, 5'd0, 16'sh8000, 16'sh7fff);
        // comp_re clips to the most negative code, whose magnitude stays negative
        send_fields(16'sh8000, 16'sd0, 16'sh7fff, 16'sd0, 1'b0);
        // energy wraps negative; doubling the scaled threshold wraps too
        send_fields(16'sd1234, -16'sd4321, 16'sh8000, 16'sh8000, 1'b1);
    endtask

    task automatic test_64qam_soft_bits();
        wait_drained();
        configure(MOD_64QAM, 5'd14, 16'sd9000, 16'sd4500);
        send_fields(16'sd12000, -16'sd3000, 16'sd8000, 16'sd2000, 1'b0);
        send_fields(-16'sd25000, 16'sd31000, -16'sd6000, 16'sd11000, 1'b0);
        send_fields(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 1'b1);
        send_fields(16'sd5, -16'sd7, 16'sd16384, -16'sd16384, 1'b0);
        wait_drained();
        configure(MOD_64QAM, 5'd31, 16'sh7fff, 16'sh8000);
        send_fields(16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 1'b1);
    endtask

    task automatic test_unused_modulation();
        wait_drained();
        configure(MOD_UNUSED, 5'd12, 16'sd10000, 16'sd3000);
        send_fields(16'sd9000, -16'sd9000, 16'sd4000, 16'sd3000, 1'b0);
        send_fields(16'sh8000, 16'sh7fff, -16'sd1, 16'sh8000, 1'b1);
    endtask

    // Phases of random elements, each under its own register setting
    task automatic test_random_traffic();
        int                 phase;
        int                 n;
        logic [1:0]         modulation;
        logic [4:0]         shift;
        logic signed [15:0] amp_a;
        logic signed [15:0] amp_b;
        t_in_item           item;
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_drained();
            case (phase)
                0: modulation = MOD_QPSK;
                1: modulation = MOD_16QAM;
                2: modulation = MOD_64QAM;
                3: modulation = MOD_UNUSED;
                default: begin
                    case ($urandom_range(0, 5))
                        0:       modulation = MOD_QPSK;
                        1, 2:    modulation = MOD_16QAM;
                        default: modulation = MOD_64QAM;
                    endcase
                end
            endcase
            if (phase == 0 || phase == 6) begin
                shift = 5'd0;
            end else if (phase == 1 || phase == 7) begin
                shift = 5'd31;
            end else if ($urandom_range(0, 9) < 7) begin
                shift = 5'($urandom_range(12, 17));
            end else begin
                shift = 5'($urandom_range(0, 31));
            end
            if (phase == 2) begin
                amp_a = 16'sh8000;
                amp_b = 16'sh7fff;
            end else if (phase == 3) begin
                amp_a = 16'sh7fff;
                amp_b = 16'sh8000;
            end else begin
                amp_a = $urandom_range(0, 1) ? 16'($urandom()) : 16'($urandom_range(0, 24000));
                amp_b = $urandom_range(0, 1) ? 16'($urandom()) : 16'($urandom_range(0, 24000));
            end
            configure(modulation, shift, amp_a, amp_b);
            sender_steady = ($urandom_range(0, 3) == 0);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                item.rx_re        = pick_sample();
                item.rx_im        = pick_sample();
                item.ch_re        = pick_sample();
                item.ch_im        = pick_sample();
                item.last_element = ($urandom_range(0, 7) == 0);
                send_element(item);
            end
            sender_steady = 1'b0;
        end
    endtask

    // ---------------------------------------------------------------- checking

    task automatic check_field(input string name, input logic [15:0] exp_val,
                               input logic [15:0] got_val);
        if (got_val !== exp_val) begin
            if (mismatch_count < MAX_REPORTS) begin
                $display("result %0d field %s: expected %h, got %h",
                         results_checked, name, exp_val, got_val);
            end
            mismatch_count++;
        end
    endtask

    // Compare each output transaction with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (pending_llrs.size() == 0) begin
                if (mismatch_count < MAX_REPORTS) begin
                    $display("result %0d arrived with no prediction pending", results_checked);
                end
                mismatch_count++;
            end else begin
                want = pending_llrs.pop_front();
                check_field("comp_re", want.comp_re, o_out_item.comp_re);
                check_field("comp_im", want.comp_im, o_out_item.comp_im);
                check_field("thr_a", want.thr_a, o_out_item.thr_a);
                check_field("thr_b", want.thr_b, o_out_item.thr_b);
                check_field("llr_0", want.llr_0, o_out_item.llr_0);
                check_field("llr_1", want.llr_1, o_out_item.llr_1);
                check_field("llr_2", want.llr_2, o_out_item.llr_2);
                check_field("llr_3", want.llr_3, o_out_item.llr_3);
                check_field("llr_4", want.llr_4, o_out_item.llr_4);
                check_field("llr_5", want.llr_5, o_out_item.llr_5);
                check_field("llr_count", 16'(want.llr_count), 16'(o_out_item.llr_count));
                check_field("last", 16'(want.last), 16'(o_out_item.last));
            end
            results_checked++;
        end
    end

    // Output stall: short bursts, occasional long holds, long free stretches
    initial begin : out_stall_gen
        int run_len;
        int hold;
        forever begin
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 6);
            repeat (run_len) begin
                @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
            hold = pick_gap();
            repeat (hold) begin
                @(negedge i_clk);
                i_out_stall <= 1'b1;
            end
        end
    end

    // Watchdog: too long without any transaction on either side
    initial begin : watchdog
        while (quiet_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid === 1'b1 && o_in_stall === 1'b0) ||
                (o_out_valid === 1'b1 && i_out_stall === 1'b0)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin : main_seq
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_qpsk_extremes();
        test_16qam_thresholds();
        test_64qam_soft_bits();
        test_unused_modulation();
        test_random_traffic();

        drop_valid();
        while (pending_llrs.size() != 0) @(posedge i_clk);
        repeat (2 * LATENCY) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
